// File: hdl/mch_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mch_pkg;

    // CORDIC iteration count (8 to 24)
    localparam int CORDIC_STAGES = 16;
    localparam int ATAN_LEN      = 24;

    // Datapath widths
    localparam int CNT_W   = 16;  // raw sensor count
    localparam int GPC_W   = 24;  // gauss per count
    localparam int OFF_W   = 18;  // hard-iron offset, Q16 gauss
    localparam int DECL_W  = 17;  // declination, Q8 degrees
    localparam int PROD_W  = 41;  // count * scale, Q32
    localparam int CAL_W   = 26;  // calibrated field, Q16, unclamped
    localparam int FIELD_W = 20;  // clamped field output
    localparam int CW      = 36;  // CORDIC x / y
    localparam int ZW      = 27;  // CORDIC angle, degrees Q16
    localparam int HSUM_W  = 28;  // angle plus declination, Q16
    localparam int HQ_W    = 20;  // heading before wrap, Q8
    localparam int HEAD_W  = 17;  // wrapped heading, Q8

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_GAUSS_PER_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Z        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DECLINATION     = 3'd4;

    // Register reset values
    localparam logic [GPC_W-1:0]         GPC_RST      = 24'd627736;
    localparam logic signed [OFF_W-1:0]  OFFSET_X_RST = -18'sd22413;
    localparam logic signed [OFF_W-1:0]  OFFSET_Y_RST = -18'sd7655;
    localparam logic signed [OFF_W-1:0]  OFFSET_Z_RST = -18'sd31044;
    localparam logic signed [DECL_W-1:0] DECL_RST     = 17'sd3029;

    // Arithmetic constants
    localparam logic signed [PROD_W-1:0]  ROUND_Q16   = 41'sd32768;
    localparam logic signed [HSUM_W-1:0]  ROUND_Q8    = 28'sd128;
    localparam logic signed [FIELD_W-1:0] FIELD_LIMIT = 20'sd458752;
    localparam logic signed [ZW-1:0]      DEG180_Q16  = 27'sd11796480;
    localparam logic signed [HQ_W-1:0]    FULL_TURN   = 20'sd92160;
    localparam logic signed [HQ_W-1:0]    TWO_TURNS   = 20'sd184320;
    localparam logic [HEAD_W-1:0]         HEADING_END = 17'd92160;

    // atan(2^-i) in degrees Q16, rounded to nearest
    localparam logic signed [ZW-1:0] ATAN_DEG_Q16 [ATAN_LEN] = '{
        27'sd2949120, 27'sd1740967, 27'sd919879, 27'sd466945,
        27'sd234379,  27'sd117304,  27'sd58666,  27'sd29335,
        27'sd14668,   27'sd7334,    27'sd3667,   27'sd1833,
        27'sd917,     27'sd458,     27'sd229,    27'sd115,
        27'sd57,      27'sd29,      27'sd14,     27'sd7,
        27'sd4,       27'sd2,       27'sd1,      27'sd0
    };

    // Input beat: six bytes of one read, low byte first per axis
    typedef struct packed {
        logic [7:0] x_low_byte;
        logic [7:0] x_high_byte;
        logic [7:0] y_low_byte;
        logic [7:0] y_high_byte;
        logic [7:0] z_low_byte;
        logic [7:0] z_high_byte;
    } in_beat_t;

    // Output beat
    typedef struct packed {
        logic signed [FIELD_W-1:0] field_x;
        logic signed [FIELD_W-1:0] field_y;
        logic signed [FIELD_W-1:0] field_z;
        logic [HEAD_W-1:0]         heading;
    } out_beat_t;

    // Clamped fields riding along the pipeline
    typedef struct packed {
        logic signed [FIELD_W-1:0] fx;
        logic signed [FIELD_W-1:0] fy;
        logic signed [FIELD_W-1:0] fz;
    } field3_t;

    // Round Q32 product to Q16 and remove the hard-iron offset
    function automatic logic signed [CAL_W-1:0] calibrate(
        input logic signed [PROD_W-1:0] prod,
        input logic signed [OFF_W-1:0]  off
    );
        logic signed [PROD_W-1:0] rnd;
        rnd = (prod + ROUND_Q16) >>> 16;
        return $signed(rnd[CAL_W-1:0]) - CAL_W'(off);
    endfunction

    // Clamp to +-7 gauss
    function automatic logic signed [FIELD_W-1:0] saturate(
        input logic signed [CAL_W-1:0] v
    );
        logic signed [CAL_W-1:0] hi;
        logic signed [CAL_W-1:0] lo;
        hi = CAL_W'(FIELD_LIMIT);
        lo = -hi;
        if (v > hi)
            return FIELD_LIMIT;
        else if (v < lo)
            return -FIELD_LIMIT;
        else
            return $signed(v[FIELD_W-1:0]);
    endfunction

endpackage

`default_nettype wire

// File: hdl/magnetometer_compass_heading.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake            Payload
// in        in   in_valid/in_ready    in_data   (six sensor bytes)
// out       out  out_valid/out_ready  out_data  (fields x/y/z, heading)
// cfg       in   cfg_valid/cfg_ready  cfg_index, cfg_data (register write)
//
// One beat per cycle sustained while the skid register is empty.
// Stages: multiply, calibrate, one CORDIC iteration each, declination, wrap.
// A stalled output parks the next result in a skid register; the pipeline
// holds while the skid is full, so in_ready drops only with both occupied.
// Reset clears valid bits and loads the register defaults; cfg is always ready.
module magnetometer_compass_heading (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  in_valid,
    output logic                                 in_ready,
    input  mch_pkg::in_beat_t                    in_data,
    output logic                                 out_valid,
    input  wire                                  out_ready,
    output mch_pkg::out_beat_t                   out_data,
    input  wire                                  cfg_valid,
    output logic                                 cfg_ready,
    input  wire [mch_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  wire [mch_pkg::CFG_DATA_W-1:0]        cfg_data
);

    localparam int N     = mch_pkg::CORDIC_STAGES;
    localparam int NPIPE = N + 3;

    // ------------------------------------------------------------------
    // Configuration registers
    logic [mch_pkg::GPC_W-1:0]         gpc_reg;
    logic signed [mch_pkg::OFF_W-1:0]  off_x_reg;
    logic signed [mch_pkg::OFF_W-1:0]  off_y_reg;
    logic signed [mch_pkg::OFF_W-1:0]  off_z_reg;
    logic signed [mch_pkg::DECL_W-1:0] decl_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gpc_reg   <= mch_pkg::GPC_RST;
            off_x_reg <= mch_pkg::OFFSET_X_RST;
            off_y_reg <= mch_pkg::OFFSET_Y_RST;
            off_z_reg <= mch_pkg::OFFSET_Z_RST;
            decl_reg  <= mch_pkg::DECL_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                mch_pkg::REG_GAUSS_PER_COUNT: gpc_reg   <= cfg_data;
                mch_pkg::REG_OFFSET_X: off_x_reg <= $signed(cfg_data[mch_pkg::OFF_W-1:0]);
                mch_pkg::REG_OFFSET_Y: off_y_reg <= $signed(cfg_data[mch_pkg::OFF_W-1:0]);
                mch_pkg::REG_OFFSET_Z: off_z_reg <= $signed(cfg_data[mch_pkg::OFF_W-1:0]);
                mch_pkg::REG_DECLINATION:
                    decl_reg <= $signed(cfg_data[mch_pkg::DECL_W-1:0]);
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control: global advance, held while the skid is full
    logic             en;
    logic [NPIPE-1:0] v_reg;
    logic             out_v_reg;
    logic             sk_v_reg;

    assign en        = !sk_v_reg;
    assign in_ready  = en;
    assign out_valid = out_v_reg;

    // ------------------------------------------------------------------
    // Stage 0: assemble counts, scale
    logic signed [mch_pkg::PROD_W-1:0] prod_x_reg;
    logic signed [mch_pkg::PROD_W-1:0] prod_y_reg;
    logic signed [mch_pkg::PROD_W-1:0] prod_z_reg;
    logic signed [mch_pkg::CNT_W-1:0]  cnt_x;
    logic signed [mch_pkg::CNT_W-1:0]  cnt_y;
    logic signed [mch_pkg::CNT_W-1:0]  cnt_z;
    logic signed [mch_pkg::GPC_W:0]    gpc_s;

    assign cnt_x = $signed({in_data.x_high_byte, in_data.x_low_byte});
    assign cnt_y = $signed({in_data.y_high_byte, in_data.y_low_byte});
    assign cnt_z = $signed({in_data.z_high_byte, in_data.z_low_byte});
    assign gpc_s = $signed({1'b0, gpc_reg});

    // ------------------------------------------------------------------
    // Stage 1: calibrate, clamp, fold the left half plane
    logic signed [mch_pkg::CAL_W-1:0] cal_x;
    logic signed [mch_pkg::CAL_W-1:0] cal_y;
    logic signed [mch_pkg::CAL_W-1:0] cal_z;
    logic signed [mch_pkg::CW-1:0]    x_init;
    logic signed [mch_pkg::CW-1:0]    y_init;
    logic signed [mch_pkg::ZW-1:0]    z_init;
    mch_pkg::field3_t                 fld_init;

    always_comb
    begin
        cal_x = mch_pkg::calibrate(prod_x_reg, off_x_reg);
        cal_y = mch_pkg::calibrate(prod_y_reg, off_y_reg);
        cal_z = mch_pkg::calibrate(prod_z_reg, off_z_reg);
        fld_init.fx = mch_pkg::saturate(cal_x);
        fld_init.fy = mch_pkg::saturate(cal_y);
        fld_init.fz = mch_pkg::saturate(cal_z);
        x_init = mch_pkg::CW'($signed({cal_x, 8'h00}));
        y_init = mch_pkg::CW'($signed({cal_y, 8'h00}));
        z_init = '0;
        if (cal_x[mch_pkg::CAL_W-1])
        begin
            x_init = -x_init;
            y_init = -y_init;
            z_init = cal_y[mch_pkg::CAL_W-1] ? -mch_pkg::DEG180_Q16 : mch_pkg::DEG180_Q16;
        end
    end

    // ------------------------------------------------------------------
    // CORDIC vectoring, one iteration per stage
    logic signed [mch_pkg::CW-1:0] cx_reg   [0:N];
    logic signed [mch_pkg::CW-1:0] cy_reg   [0:N];
    logic signed [mch_pkg::ZW-1:0] cz_reg   [0:N];
    logic                          zero_reg [0:N];
    mch_pkg::field3_t              fld_reg  [0:N+1];
    logic signed [mch_pkg::CW-1:0] cx_next  [1:N];
    logic signed [mch_pkg::CW-1:0] cy_next  [1:N];
    logic signed [mch_pkg::ZW-1:0] cz_next  [1:N];
    logic signed [mch_pkg::CW-1:0] xs;
    logic signed [mch_pkg::CW-1:0] ys;

    always_comb
    begin
        xs = '0;
        ys = '0;
        for (int k = 0; k < N; k++)
        begin
            xs = cx_reg[k] >>> k;
            ys = cy_reg[k] >>> k;
            if (!cy_reg[k][mch_pkg::CW-1])
            begin
                cx_next[k+1] = cx_reg[k] + ys;
                cy_next[k+1] = cy_reg[k] - xs;
                cz_next[k+1] = cz_reg[k] + mch_pkg::ATAN_DEG_Q16[k];
            end
            else
            begin
                cx_next[k+1] = cx_reg[k] - ys;
                cy_next[k+1] = cy_reg[k] + xs;
                cz_next[k+1] = cz_reg[k] - mch_pkg::ATAN_DEG_Q16[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // Declination add and round to Q8
    logic signed [mch_pkg::ZW-1:0]     z_eff;
    logic signed [mch_pkg::HSUM_W-1:0] h_sum;
    logic signed [mch_pkg::HSUM_W-1:0] h_rnd;
    logic signed [mch_pkg::HQ_W-1:0]   hq_next;
    logic signed [mch_pkg::HQ_W-1:0]   hq_reg;

    always_comb
    begin
        z_eff   = zero_reg[N] ? '0 : cz_reg[N];
        h_sum   = mch_pkg::HSUM_W'(z_eff)
                + mch_pkg::HSUM_W'($signed({decl_reg, 8'h00}))
                + mch_pkg::ROUND_Q8;
        h_rnd   = h_sum >>> 8;
        hq_next = $signed(h_rnd[mch_pkg::HQ_W-1:0]);
    end

    // ------------------------------------------------------------------
    // Wrap into one turn, form the result beat
    logic signed [mch_pkg::HQ_W-1:0] wrapped;
    mch_pkg::out_beat_t              res;

    always_comb
    begin
        priority if (hq_reg < -mch_pkg::FULL_TURN)
            wrapped = hq_reg + mch_pkg::TWO_TURNS;
        else if (hq_reg[mch_pkg::HQ_W-1])
            wrapped = hq_reg + mch_pkg::FULL_TURN;
        else if (hq_reg >= mch_pkg::FULL_TURN)
            wrapped = hq_reg - mch_pkg::FULL_TURN;
        else
            wrapped = hq_reg;
        res.field_x = fld_reg[N+1].fx;
        res.field_y = fld_reg[N+1].fy;
        res.field_z = fld_reg[N+1].fz;
        res.heading = wrapped[mch_pkg::HEAD_W-1:0];
    end

    // ------------------------------------------------------------------
    // Datapath registers, advance together
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_x_reg  <= cnt_x * gpc_s;
            prod_y_reg  <= cnt_y * gpc_s;
            prod_z_reg  <= cnt_z * gpc_s;
            cx_reg[0]   <= x_init;
            cy_reg[0]   <= y_init;
            cz_reg[0]   <= z_init;
            zero_reg[0] <= (cal_x == '0) && (cal_y == '0);
            fld_reg[0]  <= fld_init;
            for (int k = 1; k <= N; k++)
            begin
                cx_reg[k]   <= cx_next[k];
                cy_reg[k]   <= cy_next[k];
                cz_reg[k]   <= cz_next[k];
                zero_reg[k] <= zero_reg[k-1];
                fld_reg[k]  <= fld_reg[k-1];
            end
            fld_reg[N+1] <= fld_reg[N];
            hq_reg       <= hq_next;
        end
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[NPIPE-2:0], in_valid};
    end

    // ------------------------------------------------------------------
    // Output register and skid
    mch_pkg::out_beat_t out_reg;
    mch_pkg::out_beat_t sk_reg;

    assign out_data = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
            sk_v_reg  <= 1'b0;
        end
        else if (en)
        begin
            if (v_reg[NPIPE-1])
            begin
                if (out_v_reg && !out_ready)
                    sk_v_reg <= 1'b1;
                else
                    out_v_reg <= 1'b1;
            end
            else if (out_ready)
                out_v_reg <= 1'b0;
        end
        else if (out_ready)
            sk_v_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (v_reg[NPIPE-1])
            begin
                if (out_v_reg && !out_ready)
                    sk_reg <= res;
                else
                    out_reg <= res;
            end
        end
        else if (out_ready)
            out_reg <= sk_reg;
    end

    // ------------------------------------------------------------------
    // Assertions
    a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.heading < mch_pkg::HEADING_END))
        else $error("heading outside one turn");

    a_field_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.field_x <= mch_pkg::FIELD_LIMIT)
                   && (out_data.field_x >= -mch_pkg::FIELD_LIMIT)
                   && (out_data.field_y <= mch_pkg::FIELD_LIMIT)
                   && (out_data.field_y >= -mch_pkg::FIELD_LIMIT)
                   && (out_data.field_z <= mch_pkg::FIELD_LIMIT)
                   && (out_data.field_z >= -mch_pkg::FIELD_LIMIT))
        else $error("field outside clamp");

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        sk_v_reg |-> out_v_reg)
        else $error("skid holds a beat while output register is empty");

    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(sk_v_reg) |-> $past(out_v_reg && !out_ready && v_reg[NPIPE-1]))
        else $error("skid filled without a stalled output");

endmodule

`default_nettype wire

// File: tb/magnetometer_compass_heading_tb.sv
`timescale 1ns / 1ps

module magnetometer_compass_heading_tb;

    localparam int CYCLE_LIMIT    = 400000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int RANDOM_PHASES  = 9;
    localparam int READS_PER_PHASE = 100;
    localparam int STAGES         = mch_pkg::CORDIC_STAGES;

    // Register indexes past the last mapped one; writes there must be dropped
    localparam int UNMAPPED_FIRST = 5;
    localparam int UNMAPPED_LAST  = 7;

    // Fixed-point constants of the heading math
    localparam longint HALF_TURN_DEG_Q16 = 64'sd11796480;
    localparam longint TURN_DEG_Q8       = 64'sd92160;
    localparam longint SAT_GAUSS_Q16     = 64'sd458752;

    // atan(2^-i) in degrees, Q16, rounded to nearest
    localparam longint ATAN_STEP_Q16 [24] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    mch_pkg::in_beat_t   in_data = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    mch_pkg::out_beat_t  out_data;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [mch_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [mch_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    // Shadow copy of the calibration registers
    longint scale_q32;
    longint offset_q16 [3];
    longint decl_q8;

    mch_pkg::in_beat_t  pending_reads [$];
    mch_pkg::out_beat_t expected_headings [$];

    int items_queued  = 0;
    int results_seen  = 0;
    int mismatches    = 0;
    int reg_writes    = 0;
    int cycle_count   = 0;
    int tx_idle_pct   = 22;
    int rx_idle_pct   = 68;

    magnetometer_compass_heading i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    // Count scaled to Q16 gauss, rounded, offset removed
    function automatic longint calibrate_axis(input logic [15:0] raw, input longint off);
        longint scaled;
        scaled = longint'($signed(raw)) * scale_q32;
        return ((scaled + 64'sd32768) >>> 16) - off;
    endfunction

    function automatic logic signed [mch_pkg::FIELD_W-1:0] clamp_gauss(input longint f);
        longint c;
        c = f;
        if (c > SAT_GAUSS_Q16)
            c = SAT_GAUSS_Q16;
        if (c < -SAT_GAUSS_Q16)
            c = -SAT_GAUSS_Q16;
        return c[mch_pkg::FIELD_W-1:0];
    endfunction

    // Vectoring CORDIC: atan2(y, x) in degrees Q16
    function automatic longint cordic_angle_q16(input longint fx, input longint fy);
        longint x;
        longint y;
        longint z;
        longint xs;
        longint ys;
        int i;
        if (fx == 0 && fy == 0)
            return 0;
        x = fx * 256;
        y = fy * 256;
        z = 0;
        // left half plane: flip and start from +-180
        if (x < 0)
        begin
            z = (y >= 0) ? HALF_TURN_DEG_Q16 : -HALF_TURN_DEG_Q16;
            x = -x;
            y = -y;
        end
        for (i = 0; i < STAGES && i < 24; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0)
            begin
                x = x + ys;
                y = y - xs;
                z = z + ATAN_STEP_Q16[i];
            end
            else
            begin
                x = x - ys;
                y = y + xs;
                z = z - ATAN_STEP_Q16[i];
            end
        end
        return z;
    endfunction

    function automatic mch_pkg::out_beat_t predict_heading(input mch_pkg::in_beat_t b);
        mch_pkg::out_beat_t r;
        longint fx;
        longint fy;
        longint fz;
        longint h;
        longint wrapped;
        fx = calibrate_axis({b.x_high_byte, b.x_low_byte}, offset_q16[0]);
        fy = calibrate_axis({b.y_high_byte, b.y_low_byte}, offset_q16[1]);
        fz = calibrate_axis({b.z_high_byte, b.z_low_byte}, offset_q16[2]);
        h = cordic_angle_q16(fx, fy) + decl_q8 * 256;
        wrapped = ((h + 128) >>> 8) % TURN_DEG_Q8;
        if (wrapped < 0)
            wrapped = wrapped + TURN_DEG_Q8;
        r.field_x = clamp_gauss(fx);
        r.field_y = clamp_gauss(fy);
        r.field_z = clamp_gauss(fz);
        r.heading = wrapped[mch_pkg::HEAD_W-1:0];
        return r;
    endfunction

    // Register write; bits above the register width carry junk
    task automatic write_reg(input logic [mch_pkg::CFG_IDX_W-1:0] idx,
                             input longint value);
        logic [mch_pkg::CFG_DATA_W-1:0] keep;
        logic [mch_pkg::CFG_DATA_W-1:0] data;
        case (idx)
            mch_pkg::REG_GAUSS_PER_COUNT: keep = '1;
            mch_pkg::REG_OFFSET_X, mch_pkg::REG_OFFSET_Y, mch_pkg::REG_OFFSET_Z:
                keep = 24'h03FFFF;
            mch_pkg::REG_DECLINATION: keep = 24'h01FFFF;
            default: keep = '0;
        endcase
        data = (mch_pkg::CFG_DATA_W'(value) & keep)
             | (mch_pkg::CFG_DATA_W'($urandom) & ~keep);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            mch_pkg::REG_GAUSS_PER_COUNT: scale_q32 = longint'(data[23:0]);
            mch_pkg::REG_OFFSET_X: offset_q16[0] = longint'($signed(data[17:0]));
            mch_pkg::REG_OFFSET_Y: offset_q16[1] = longint'($signed(data[17:0]));
            mch_pkg::REG_OFFSET_Z: offset_q16[2] = longint'($signed(data[17:0]));
            mch_pkg::REG_DECLINATION: decl_q8 = longint'($signed(data[16:0]));
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic queue_read(input logic [15:0] cx, input logic [15:0] cy,
                              input logic [15:0] cz);
        mch_pkg::in_beat_t b;
        b.x_low_byte  = cx[7:0];
        b.x_high_byte = cx[15:8];
        b.y_low_byte  = cy[7:0];
        b.y_high_byte = cy[15:8];
        b.z_low_byte  = cz[7:0];
        b.z_high_byte = cz[15:8];
        pending_reads.push_back(b);
        items_queued++;
    endtask

    // Block until every queued read has produced its result
    task automatic wait_drained();
        @(negedge clk);
        while (results_seen != items_queued)
            @(negedge clk);
    endtask

    function automatic logic [15:0] pick_count(input int kind);
        int v;
        case (kind)
            2:
            begin
                v = int'($urandom_range(16)) - 8;
                return v[15:0];
            end
            3:
            begin
                case ($urandom_range(4))
                    0: return 16'h7FFF;
                    1: return 16'h8000;
                    2: return 16'h0000;
                    3: return 16'hFFFF;
                    default: return 16'($urandom);
                endcase
            end
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic longint pick_offset();
        case ($urandom_range(3))
            0: return -131072;
            1: return 131071;
            2: return 0;
            default: return longint'($urandom_range(262143)) - 131072;
        endcase
    endfunction

    // Sender: presents the next pending read, with random gaps
    always @(posedge clk or negedge rst_n)
    begin
        logic fire;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
        end
        else
        begin
            fire = in_valid && in_ready;
            if (fire)
                expected_headings.push_back(predict_heading(in_data));
            if ((!in_valid || fire) && pending_reads.size() != 0 &&
                $urandom_range(99) >= tx_idle_pct)
            begin
                in_valid <= 1'b1;
                in_data  <= pending_reads.pop_front();
            end
            else if (fire)
                in_valid <= 1'b0;
        end
    end

    // Receiver: random backpressure, checks each result beat
    always @(posedge clk or negedge rst_n)
    begin
        mch_pkg::out_beat_t want;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (expected_headings.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("unexpected result beat: x=%0d y=%0d z=%0d hdg=%0d",
                                 out_data.field_x, out_data.field_y,
                                 out_data.field_z, out_data.heading);
                    mismatches++;
                end
                else
                begin
                    want = expected_headings.pop_front();
                    if (out_data.field_x !== want.field_x ||
                        out_data.field_y !== want.field_y ||
                        out_data.field_z !== want.field_z ||
                        out_data.heading !== want.heading)
                    begin
                        if (mismatches < 10)
                        begin
                            $display("mismatch on result %0d: want x=%0d y=%0d z=%0d hdg=%0d",
                                     results_seen, want.field_x, want.field_y,
                                     want.field_z, want.heading);
                            $display("    got x=%0d y=%0d z=%0d hdg=%0d",
                                     out_data.field_x, out_data.field_y,
                                     out_data.field_z, out_data.heading);
                        end
                        mismatches++;
                    end
                end
            end
            out_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        int ph;
        int n;
        int k;
        int kind;
        scale_q32     = 627736;
        offset_q16[0] = -22413;
        offset_q16[1] = -7655;
        offset_q16[2] = -31044;
        decl_q8       = 3029;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: zero, full-scale and all-ones counts with the reset calibration
        queue_read(16'h0000, 16'h0000, 16'h0000);
        queue_read(16'h7FFF, 16'h8000, 16'h7FFF);
        queue_read(16'h8000, 16'h7FFF, 16'h8000);
        queue_read(16'hFFFF, 16'hFFFF, 16'hFFFF);
        wait_drained();

        // Unity scale, no offsets: counts map straight to the CORDIC inputs
        write_reg(mch_pkg::REG_GAUSS_PER_COUNT, 65536);
        write_reg(mch_pkg::REG_OFFSET_X, 0);
        write_reg(mch_pkg::REG_OFFSET_Y, 0);
        write_reg(mch_pkg::REG_OFFSET_Z, 0);
        write_reg(mch_pkg::REG_DECLINATION, 0);
        queue_read(16'd0, 16'd0, 16'd0);            // zero vector
        queue_read(16'd5, 16'd0, 16'd0);
        queue_read(-16'sd5, 16'd0, 16'd0);          // negative x axis, exactly 180
        queue_read(16'd0, 16'd5, 16'd0);
        queue_read(16'd0, -16'sd5, 16'd0);
        queue_read(-16'sd5, -16'sd5, 16'd0);        // third quadrant
        queue_read(-16'sd5, 16'd5, 16'd1);          // second quadrant
        queue_read(16'd5, -16'sd5, -16'sd1);
        queue_read(16'h8000, 16'hFFFF, 16'd0);
        queue_read(16'h8000, 16'd0, 16'd7);
        wait_drained();

        // Declination at +-180 degrees: wrap upward and downward
        write_reg(mch_pkg::REG_DECLINATION, 46080);
        for (k = UNMAPPED_FIRST; k <= UNMAPPED_LAST; k++)
            write_reg(mch_pkg::CFG_IDX_W'(k), 0);
        queue_read(16'd0, 16'd0, 16'd0);
        queue_read(-16'sd5, 16'd0, 16'd0);
        wait_drained();
        write_reg(mch_pkg::REG_DECLINATION, -46080);
        queue_read(16'd0, 16'd0, 16'd0);
        queue_read(-16'sd5, 16'd0, 16'd0);
        wait_drained();

        // Largest scale and offsets: field saturation both ways
        write_reg(mch_pkg::REG_GAUSS_PER_COUNT, 24'hFFFFFF);
        write_reg(mch_pkg::REG_OFFSET_X, -131072);
        write_reg(mch_pkg::REG_OFFSET_Y, 131071);
        write_reg(mch_pkg::REG_OFFSET_Z, -131072);
        write_reg(mch_pkg::REG_DECLINATION, -65536);
        queue_read(16'h7FFF, 16'h8000, 16'h7FFF);
        queue_read(16'h8000, 16'h7FFF, 16'h0000);
        wait_drained();

        // Random phases: fresh calibration each, three idle mixes
        for (ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case (ph / 3)
                0:
                begin
                    tx_idle_pct = 22;
                    rx_idle_pct = 68;
                end
                1:
                begin
                    tx_idle_pct = 68;
                    rx_idle_pct = 22;
                end
                default:
                begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            case ($urandom_range(4))
                0: write_reg(mch_pkg::REG_GAUSS_PER_COUNT, 0);
                1: write_reg(mch_pkg::REG_GAUSS_PER_COUNT, 24'hFFFFFF);
                2: write_reg(mch_pkg::REG_GAUSS_PER_COUNT, 65536);
                3: write_reg(mch_pkg::REG_GAUSS_PER_COUNT, $urandom_range(70000));
                default: write_reg(mch_pkg::REG_GAUSS_PER_COUNT, $urandom_range(24'hFFFFFF));
            endcase
            write_reg(mch_pkg::REG_OFFSET_X, pick_offset());
            write_reg(mch_pkg::REG_OFFSET_Y, pick_offset());
            write_reg(mch_pkg::REG_OFFSET_Z, pick_offset());
            case ($urandom_range(3))
                0: write_reg(mch_pkg::REG_DECLINATION, -46080);
                1: write_reg(mch_pkg::REG_DECLINATION, 46080);
                2: write_reg(mch_pkg::REG_DECLINATION,
                             longint'($urandom_range(92160)) - 46080);
                default: write_reg(mch_pkg::REG_DECLINATION,
                                   longint'($urandom_range(131071)) - 65536);
            endcase
            if ($urandom_range(3) == 0)
                write_reg(mch_pkg::CFG_IDX_W'($urandom_range(UNMAPPED_LAST,
                                                               UNMAPPED_FIRST)), 0);

            // kind 0/1: any bytes, 2: counts near zero, 3: rail values, zero or any bytes
            for (n = 0; n < READS_PER_PHASE; n++)
            begin
                kind = $urandom_range(3);
                queue_read(pick_count(kind), pick_count(kind), pick_count(kind));
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_headings.size() != 0)
        begin
            $display("%0d expected results never came out", expected_headings.size());
            mismatches += expected_headings.size();
        end

        $display("checked %0d sensor reads, %0d register writes, %0d cycles",
                 results_seen, reg_writes, cycle_count);
        $display("stall mixes: sender-heavy, receiver-heavy, none; %0d mismatches",
                 mismatches);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// File: files.f
hdl/mch_pkg.sv
hdl/magnetometer_compass_heading.sv
tb/magnetometer_compass_heading_tb.sv
